>>> rtl/bilinear_image_scaler_macros.svh
// Assertion macros for the bilinear image scaler.
// Included by the RTL files that carry concurrent assertions.
`ifndef BILINEAR_IMAGE_SCALER_MACROS_SVH
`define BILINEAR_IMAGE_SCALER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define BIS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bis assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define BIS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bis assertion failed");
`else
`define BIS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BIS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/bis_pkg.sv
// Package for the bilinear image scaler: widths, caps, codes and shared types.
// No dependencies; every other RTL file imports it.
`default_nettype none
package bis_pkg;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int LANES_DEF     = 4;
    localparam int CH_W          = 8;
    localparam int HEIGHT_CAP    = 1024;
    localparam int OUT_CAP       = 4096;
    localparam int RESULT_CAP    = 64;
    localparam int RES_CNT_W     = 7;
    localparam int CNT_W         = 14;
    localparam int ROW_W         = 10;
    localparam int NUM_W         = 26;
    localparam int DEN_W         = 12;
    localparam int AX_W          = 15;
    localparam int CRD_W         = 13;
    localparam int OUTC_W        = 12;
    localparam int WT_W          = 12;
    localparam int LDEN_W        = 24;
    localparam int LANE_DEPTH    = 11;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 13;
    localparam int IN_W_W        = 11;
    localparam int IN_H_W        = 11;
    localparam int OUT_W_W       = 13;
    localparam int CHN_W         = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_WIDTH   = 3'd0,
        CFG_IN_HEIGHT  = 3'd1,
        CFG_OUT_WIDTH  = 3'd2,
        CFG_OUT_HEIGHT = 3'd3,
        CFG_CHANNELS   = 3'd4
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_WAIT,
        S_GEN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
        logic [DEN_W-1:0] rem;
    } t_div_res;
endpackage
`default_nettype wire

>>> rtl/bis_if.sv
// Valid/ready channel interfaces of the bilinear image scaler.
// Depends on bis_pkg for field widths.
`default_nettype none
interface bis_pix_if;
    import bis_pkg::*;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] sample_a;
    logic [CH_W-1:0] sample_b;
    logic [CH_W-1:0] sample_c;
    logic [CH_W-1:0] sample_d;
    modport source (output valid, sample_a, sample_b, sample_c, sample_d, input ready);
    modport sink (input valid, sample_a, sample_b, sample_c, sample_d, output ready);
endinterface

interface bis_res_if;
    import bis_pkg::*;
    logic              valid;
    logic              ready;
    logic [OUTC_W-1:0] out_x;
    logic [OUTC_W-1:0] out_y;
    logic [CH_W-1:0]   value_a;
    logic [CH_W-1:0]   value_b;
    logic [CH_W-1:0]   value_c;
    logic [CH_W-1:0]   value_d;
    logic              run_end;
    modport source (output valid, out_x, out_y, value_a, value_b, value_c, value_d,
                    run_end, input ready);
    modport sink (input valid, out_x, out_y, value_a, value_b, value_c, value_d,
                  run_end, output ready);
endinterface

interface bis_cfg_if;
    import bis_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;
    modport source (output valid, reg_index, wr_data, input ready);
    modport sink (input valid, reg_index, wr_data, output ready);
endinterface
`default_nettype wire

>>> rtl/bis_cdiv.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on bis_pkg for widths and the result struct.
`default_nettype none
module bis_cdiv (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_start,
    input  wire [bis_pkg::NUM_W-1:0] i_num,
    input  wire [bis_pkg::DEN_W-1:0] i_den,
    output bis_pkg::t_div_res       o_res
);
    import bis_pkg::*;
    localparam int CW = $clog2(NUM_W + 1);

    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_r;
    logic [DEN_W-1:0] r_d;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb begin
        trial = {r_r, r_q[NUM_W-1]};
        ge    = trial >= {1'b0, r_d};
        diff  = trial - {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_num;
            r_r <= '0;
            r_d <= i_den;
        end else if (r_busy) begin
            r_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_q <= {r_q[NUM_W-2:0], ge};
        end
    end

    assign o_res.done = r_done;
    assign o_res.quo  = r_q;
    assign o_res.rem  = r_r;
endmodule
`default_nettype wire

>>> rtl/bis_lane.sv
// One channel lane: weighted corner sum and pipelined rounding divide.
// Depends on bis_pkg for widths; the channel width also sets the divide depth.
`default_nettype none
module bis_lane (
    input  wire                       i_clk,
    input  wire                       i_en,
    input  wire [bis_pkg::WT_W-1:0]   i_ax,
    input  wire [bis_pkg::WT_W-1:0]   i_bx,
    input  wire [bis_pkg::WT_W-1:0]   i_ay,
    input  wire [bis_pkg::WT_W-1:0]   i_by,
    input  wire [bis_pkg::CH_W-1:0]   i_a,
    input  wire [bis_pkg::CH_W-1:0]   i_b,
    input  wire [bis_pkg::CH_W-1:0]   i_c,
    input  wire [bis_pkg::CH_W-1:0]   i_d,
    input  wire [bis_pkg::LDEN_W-1:0] i_den,
    output logic [bis_pkg::CH_W-1:0]  o_value
);
    import bis_pkg::*;
    localparam int P_W  = WT_W + CH_W + 1;
    localparam int M_W  = WT_W + P_W;
    localparam int R_W  = M_W + 2;
    localparam int DV_W = R_W + CH_W;

    logic [P_W-1:0]  r_p1, r_p2;
    logic [WT_W-1:0] r_ay, r_by;
    logic [M_W-1:0]  r_m1, r_m2;
    logic [R_W-1:0]  r_r2;
    logic [R_W-1:0]  r_rem [CH_W];
    logic [CH_W-1:0] r_q   [CH_W];

    // Stages 1 to 3: products of the corner weights, then their doubled sum plus the denominator.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1 <= P_W'(i_ax * i_d) + P_W'(i_bx * i_c);
            r_p2 <= P_W'(i_ax * i_b) + P_W'(i_bx * i_a);
            r_ay <= i_ay;
            r_by <= i_by;
            r_m1 <= M_W'(r_ay * r_p1);
            r_m2 <= M_W'(r_by * r_p2);
            r_r2 <= {(M_W+1)'(r_m1) + (M_W+1)'(r_m2), 1'b0} + R_W'(i_den);
        end
    end

    // Stages 4 to 11: one quotient bit each, most significant first.
    for (genvar j = 0; j < CH_W; j++) begin : g_div
        logic [DV_W-1:0] dv;
        logic [R_W-1:0]  rem_in;
        logic [CH_W-1:0] q_in;
        logic            ge;
        always_comb begin
            dv = DV_W'({i_den, 1'b0}) << (CH_W - 1 - j);
            if (j == 0) begin
                rem_in = r_r2;
                q_in   = '0;
            end else begin
                rem_in = r_rem[(j == 0) ? 0 : j - 1];
                q_in   = r_q[(j == 0) ? 0 : j - 1];
            end
            ge = DV_W'(rem_in) >= dv;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= ge ? R_W'(DV_W'(rem_in) - dv) : rem_in;
                r_q[j]   <= q_in | (CH_W'(ge) << (CH_W - 1 - j));
            end
        end
    end

    assign o_value = r_q[CH_W-1];
endmodule
`default_nettype wire

>>> rtl/bilinear_image_scaler.sv
// Streaming corner-aligned bilinear scaler. Input pixels come in raster order with up to
// four 8-bit channels; one line of the previous row is held in an on-chip memory. When
// pixel (r,c) with r,c >= 1 arrives, the block emits every output pixel of the cell whose
// corners are (r-1,c-1) .. (r,c), row-major, at most 64, with run_end on the last one.
// A pixel that opens a cell goes through setup, a wait on the serial dividers that find the
// first output column and row of the cell, one result per cycle while the output is not
// stalled (a cell that holds no output pixel still passes through that state), and a last
// state that updates the line memory. Pixels that open no cell skip the divide and go
// straight to the line memory update. Results come out through the lane pipelines; a
// stalled output freezes the whole pipeline. There is no clearing pass after reset.
`default_nettype none
`include "bilinear_image_scaler_macros.svh"
module bilinear_image_scaler #(
    parameter int MAX_WIDTH = bis_pkg::MAX_WIDTH_DEF,
    parameter int LANES     = bis_pkg::LANES_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    bis_pix_if.sink    i_pix,
    bis_res_if.source  o_res,
    bis_cfg_if.sink    i_cfg
);
    import bis_pkg::*;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int PIX_W = CH_W * LANES;

    // Configuration registers.
    logic [IN_W_W-1:0]  r_in_w;
    logic [IN_H_W-1:0]  r_in_h;
    logic [OUT_W_W-1:0] r_out_w;
    logic [OUT_W_W-1:0] r_out_h;
    logic [CHN_W-1:0]   r_ch;
    logic [LDEN_W-1:0]  r_den;

    // Clamped working values.
    logic [CNT_W-1:0]   in_w_x, w_c;
    logic [IN_H_W-1:0]  h_c;
    logic [OUT_W_W-1:0] ow_c, oh_c;
    logic [CHN_W-1:0]   ch_c;
    logic [WT_W-1:0]    wx, wy;
    logic [DEN_W-1:0]   sx, sy;

    // Frame position and pixel neighbors.
    t_state             r_state, n_state;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [PIX_W-1:0]   r_pix, r_rd, r_left_cur, r_left_above;
    logic [PIX_W-1:0]   r_line [MAX_WIDTH];

    // Cell walk.
    logic [CRD_W-1:0]     r_x, r_x0, r_y;
    logic [AX_W-1:0]      r_ax, r_ax0, r_ay;
    logic [RES_CNT_W-1:0] r_n;
    logic                 r_lastx, r_lasty;

    // Sideband pipeline alongside the lanes.
    logic                 r_sv [LANE_DEPTH];
    logic [OUTC_W-1:0]    r_sx [LANE_DEPTH];
    logic [OUTC_W-1:0]    r_sy [LANE_DEPTH];
    logic                 r_sl [LANE_DEPTH];

    logic                 pix_acc, en, issue, gen_last, div_start;
    logic                 xok, yok, xok_nx, yok_nx;
    logic [AX_W-1:0]      ax_nx, ay_nx, wx_x, wy_x;
    logic [CNT_W-1:0]     col_x, col_n;
    logic                 col_wrap;
    logic [COL_W-1:0]     col_e;
    logic [ROW_W:0]       row_t, row_n;
    logic [ROW_W-1:0]     row_e;
    logic [COL_W-1:0]     cc;
    logic [ROW_W-1:0]     cr;
    logic [COL_W+WT_W-1:0] prod_x;
    logic [ROW_W+WT_W-1:0] prod_y;
    t_div_res             w_xdiv, w_ydiv;
    logic [CH_W-1:0]      w_val [LANES];
    logic [CH_W-1:0]      smp [4];
    logic [CH_W-1:0]      val_out [4];
    logic [PIX_W-1:0]     pix_in;

    // Clamp the registers to their working ranges.
    always_comb begin
        in_w_x = CNT_W'(r_in_w);
        if (in_w_x < CNT_W'(2)) begin
            w_c = CNT_W'(2);
        end else if (in_w_x > CNT_W'(MAX_WIDTH)) begin
            w_c = CNT_W'(MAX_WIDTH);
        end else begin
            w_c = in_w_x;
        end
        h_c  = (r_in_h < IN_H_W'(2)) ? IN_H_W'(2) :
               (r_in_h > IN_H_W'(HEIGHT_CAP)) ? IN_H_W'(HEIGHT_CAP) : r_in_h;
        ow_c = (r_out_w < OUT_W_W'(2)) ? OUT_W_W'(2) :
               (r_out_w > OUT_W_W'(OUT_CAP)) ? OUT_W_W'(OUT_CAP) : r_out_w;
        oh_c = (r_out_h < OUT_W_W'(2)) ? OUT_W_W'(2) :
               (r_out_h > OUT_W_W'(OUT_CAP)) ? OUT_W_W'(OUT_CAP) : r_out_h;
        ch_c = (r_ch < CHN_W'(1)) ? CHN_W'(1) :
               (r_ch > CHN_W'(LANES)) ? CHN_W'(LANES) : r_ch;
        wx   = WT_W'(ow_c - OUT_W_W'(1));
        wy   = WT_W'(oh_c - OUT_W_W'(1));
        sx   = DEN_W'(w_c - CNT_W'(1));
        sy   = DEN_W'(h_c - IN_H_W'(1));
    end

    // Configuration writes are taken at any time; the user writes only while idle.
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_w  <= IN_W_W'(2);
            r_in_h  <= IN_H_W'(2);
            r_out_w <= OUT_W_W'(2);
            r_out_h <= OUT_W_W'(2);
            r_ch    <= CHN_W'(1);
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.reg_index))
                CFG_IN_WIDTH:   r_in_w  <= i_cfg.wr_data[IN_W_W-1:0];
                CFG_IN_HEIGHT:  r_in_h  <= i_cfg.wr_data[IN_H_W-1:0];
                CFG_OUT_WIDTH:  r_out_w <= i_cfg.wr_data[OUT_W_W-1:0];
                CFG_OUT_HEIGHT: r_out_h <= i_cfg.wr_data[OUT_W_W-1:0];
                CFG_CHANNELS:   r_ch    <= i_cfg.wr_data[CHN_W-1:0];
                default: ;
            endcase
        end
    end

    // The rounding denominator is registered so its multiplier stands alone.
    always_ff @(posedge i_clk) begin
        r_den <= LDEN_W'(wx * wy);
    end

    // Input pixel and the position it lands on, after wrapping a shrunk frame.
    assign smp = '{i_pix.sample_a, i_pix.sample_b, i_pix.sample_c, i_pix.sample_d};
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            pix_in[CH_W*k +: CH_W] = smp[k];
        end
        col_x    = CNT_W'(r_col);
        col_wrap = col_x >= w_c;
        col_e    = col_wrap ? '0 : r_col;
        row_t    = {1'b0, r_row} + (ROW_W+1)'(col_wrap);
        row_e    = (row_t >= h_c) ? '0 : row_t[ROW_W-1:0];
        col_n    = col_x + CNT_W'(1);
        row_n    = {1'b0, r_row} + (ROW_W+1)'(1);
    end

    assign i_pix.ready = (r_state == S_IDLE);
    assign pix_acc     = i_pix.valid && i_pix.ready;

    // Products that feed the dividers: first output column and row of the cell.
    assign cc     = r_col - COL_W'(1);
    assign cr     = r_row - ROW_W'(1);
    assign prod_x = cc * wx;
    assign prod_y = cr * wy;
    assign div_start = (r_state == S_DIV);

    bis_cdiv u_xdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (NUM_W'(prod_x)),
        .i_den   (sx),
        .o_res   (w_xdiv)
    );

    bis_cdiv u_ydiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (NUM_W'(prod_y)),
        .i_den   (sy),
        .o_res   (w_ydiv)
    );

    // Walk conditions. A position lies in the cell while its offset from the near edge is
    // below the span; the last cell on an axis also takes its far edge.
    always_comb begin
        wx_x   = AX_W'(wx);
        wy_x   = AX_W'(wy);
        ax_nx  = r_ax + AX_W'(sx);
        ay_nx  = r_ay + AX_W'(sy);
        xok    = r_lastx ? (r_ax <= wx_x) : (r_ax < wx_x);
        yok    = r_lasty ? (r_ay <= wy_x) : (r_ay < wy_x);
        xok_nx = r_lastx ? (ax_nx <= wx_x) : (ax_nx < wx_x);
        yok_nx = r_lasty ? (ay_nx <= wy_x) : (ay_nx < wy_x);
    end

    // The pipeline moves whenever the output register is empty or being taken.
    assign en       = !r_sv[LANE_DEPTH-1] || o_res.ready;
    assign issue    = (r_state == S_GEN) && en && xok && yok;
    assign gen_last = (r_n == RES_CNT_W'(RESULT_CAP - 1)) || (!xok_nx && !yok_nx);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (pix_acc) begin
                    n_state = (row_e != '0 && col_e != '0) ? S_DIV : S_FIN;
                end
            end
            S_DIV: n_state = S_WAIT;
            S_WAIT: begin
                if (w_xdiv.done && w_ydiv.done) begin
                    n_state = S_GEN;
                end
            end
            S_GEN: begin
                if (en && (!(xok && yok) || gen_last)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Frame position and the left neighbors, all cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_left_cur   <= '0;
            r_left_above <= '0;
        end else if (pix_acc) begin
            r_col <= col_e;
            r_row <= row_e;
        end else if (r_state == S_FIN) begin
            r_left_above <= r_rd;
            r_left_cur   <= r_pix;
            if (col_n >= w_c) begin
                r_col <= '0;
                r_row <= (row_n >= h_c) ? '0 : row_n[ROW_W-1:0];
            end else begin
                r_col <= COL_W'(col_n);
            end
        end
    end

    // Line memory: read the pixel above on transfer, write the new pixel at the end.
    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_rd  <= r_line[col_e];
            r_pix <= pix_in;
        end
        if (r_state == S_FIN) begin
            r_line[r_col] <= r_pix;
        end
    end

    // Cell walk registers. The first column and row come from the ceiling division;
    // the offset there is the divisor minus the remainder, or zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0;
        end else if (r_state == S_WAIT && w_xdiv.done && w_ydiv.done) begin
            r_n <= '0;
        end else if (issue) begin
            r_n <= r_n + RES_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WAIT && w_xdiv.done && w_ydiv.done) begin
            r_x0    <= CRD_W'(w_xdiv.quo) + CRD_W'(w_xdiv.rem != '0);
            r_x     <= CRD_W'(w_xdiv.quo) + CRD_W'(w_xdiv.rem != '0);
            r_ax0   <= (w_xdiv.rem != '0) ? AX_W'(sx - w_xdiv.rem) : '0;
            r_ax    <= (w_xdiv.rem != '0) ? AX_W'(sx - w_xdiv.rem) : '0;
            r_y     <= CRD_W'(w_ydiv.quo) + CRD_W'(w_ydiv.rem != '0);
            r_ay    <= (w_ydiv.rem != '0) ? AX_W'(sy - w_ydiv.rem) : '0;
            r_lastx <= DEN_W'(cc) == sx - DEN_W'(1);
            r_lasty <= DEN_W'(cr) == sy - DEN_W'(1);
        end else if (issue && !gen_last) begin
            if (xok_nx) begin
                r_x  <= r_x + CRD_W'(1);
                r_ax <= ax_nx;
            end else begin
                r_x  <= r_x0;
                r_ax <= r_ax0;
                r_y  <= r_y + CRD_W'(1);
                r_ay <= ay_nx;
            end
        end
    end

    // Channel lanes; each gets the same weights and its own four corner samples.
    for (genvar k = 0; k < LANES; k++) begin : g_lane
        bis_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_ax    (r_ax[WT_W-1:0]),
            .i_bx    (wx - r_ax[WT_W-1:0]),
            .i_ay    (r_ay[WT_W-1:0]),
            .i_by    (wy - r_ay[WT_W-1:0]),
            .i_a     (r_left_above[CH_W*k +: CH_W]),
            .i_b     (r_rd[CH_W*k +: CH_W]),
            .i_c     (r_left_cur[CH_W*k +: CH_W]),
            .i_d     (r_pix[CH_W*k +: CH_W]),
            .i_den   (r_den),
            .o_value (w_val[k])
        );
    end

    // Sideband pipeline: coordinates, run end and valid travel with the lanes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LANE_DEPTH; s++) begin
                r_sv[s] <= 1'b0;
            end
        end else if (en) begin
            r_sv[0] <= issue;
            for (int s = 1; s < LANE_DEPTH; s++) begin
                r_sv[s] <= r_sv[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sx[0] <= r_x[OUTC_W-1:0];
            r_sy[0] <= r_y[OUTC_W-1:0];
            r_sl[0] <= gen_last;
            for (int s = 1; s < LANE_DEPTH; s++) begin
                r_sx[s] <= r_sx[s-1];
                r_sy[s] <= r_sy[s-1];
                r_sl[s] <= r_sl[s-1];
            end
        end
    end

    // Merge the lanes into the result; unused channels read as zero.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            val_out[k] = '0;
        end
        for (int k = 0; k < LANES; k++) begin
            val_out[k] = (CHN_W'(k) < ch_c) ? w_val[k] : '0;
        end
    end

    assign o_res.valid   = r_sv[LANE_DEPTH-1];
    assign o_res.out_x   = r_sx[LANE_DEPTH-1];
    assign o_res.out_y   = r_sy[LANE_DEPTH-1];
    assign o_res.run_end = r_sl[LANE_DEPTH-1];
    assign o_res.value_a = val_out[0];
    assign o_res.value_b = val_out[1];
    assign o_res.value_c = val_out[2];
    assign o_res.value_d = val_out[3];

    // Both dividers start together and run the same number of steps.
    `BIS_ASSERT_IMP(a_div_sync, i_clk, i_rst_n, 1'b1, w_xdiv.done == w_ydiv.done)
    // No cell issues more results than the cap.
    `BIS_ASSERT_IMP(a_res_cap, i_clk, i_rst_n, r_state == S_GEN, r_n < RES_CNT_W'(RESULT_CAP))
    // An issued position never lies past the cell's far edge.
    `BIS_ASSERT_IMP(a_in_cell, i_clk, i_rst_n, issue, r_ax <= wx_x && r_ay <= wy_x)
    // The memory update state is always followed by the idle state, ready for the next transfer.
    `BIS_ASSERT_NXT(a_fin_idle, i_clk, i_rst_n, r_state == S_FIN, r_state == S_IDLE)
endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the streaming bilinear image scaler.
// Depends on bis_pkg and the channel interfaces in bis_if.sv, and on the RTL top level.
`default_nettype none

typedef struct {
    int unsigned px;
    int unsigned py;
    int unsigned val[4];
    bit          last;
} t_out_pixel;

// Predicts every output pixel for the accepted input pixels, then checks the results.
class scaler_scoreboard;
    bit [10:0]   in_w_reg, in_h_reg;
    bit [12:0]   out_w_reg, out_h_reg;
    bit [2:0]    chan_reg;
    bit [31:0]   prev_line[1024];
    bit [31:0]   left_cur, left_up;
    int unsigned col, row;
    t_out_pixel  expected_pixels[$];
    int          errors;

    function new();
        in_w_reg = 11'd2; in_h_reg = 11'd2; out_w_reg = 13'd2; out_h_reg = 13'd2;
        chan_reg = 3'd1;
        left_cur = '0; left_up = '0; col = 0; row = 0; errors = 0;
        foreach (prev_line[i]) prev_line[i] = '0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void write_reg(bis_pkg::t_cfg_reg idx, bit [12:0] data);
        case (idx)
            bis_pkg::CFG_IN_WIDTH:   in_w_reg = data[10:0];
            bis_pkg::CFG_IN_HEIGHT:  in_h_reg = data[10:0];
            bis_pkg::CFG_OUT_WIDTH:  out_w_reg = data;
            bis_pkg::CFG_OUT_HEIGHT: out_h_reg = data;
            bis_pkg::CFG_CHANNELS:   chan_reg = data[2:0];
            default: ;
        endcase
    endfunction

    function void note_pixel(bit [31:0] pix);
        int unsigned w, h, ow, oh, ch, n, k;
        longint unsigned cc, cr, wx, wy, sx, sy, den, x0, x1, y0, y1, ax, bx, ay, by, num, v;
        bit [31:0]   up;
        t_out_pixel  o;
        w = clamp(in_w_reg, 2, 1024);
        h = clamp(in_h_reg, 2, 1024);
        ow = clamp(out_w_reg, 2, 4096);
        oh = clamp(out_h_reg, 2, 4096);
        ch = clamp(chan_reg, 1, 4);
        n = 0;
        // A counter left past a shrunk size wraps before the pixel is placed.
        if (col >= w) begin
            col = 0;
            row++;
        end
        if (row >= h) row = 0;
        up = prev_line[col];
        if (row >= 1 && col >= 1) begin
            cc = col - 1; cr = row - 1;
            wx = ow - 1; wy = oh - 1; sx = w - 1; sy = h - 1;
            den = wx * wy;
            x0 = (cc * wx + sx - 1) / sx;
            x1 = (cc == sx - 1) ? ow : ((cc + 1) * wx + sx - 1) / sx;
            y0 = (cr * wy + sy - 1) / sy;
            y1 = (cr == sy - 1) ? oh : ((cr + 1) * wy + sy - 1) / sy;
            for (longint unsigned y = y0; y < y1 && n < 64; y++) begin
                ay = y * sy - cr * wy;
                by = wy - ay;
                for (longint unsigned x = x0; x < x1 && n < 64; x++) begin
                    ax = x * sx - cc * wx;
                    bx = wx - ax;
                    o.px = x[11:0];
                    o.py = y[11:0];
                    o.last = 0;
                    for (k = 0; k < 4; k++) begin
                        v = 0;
                        if (k < ch) begin
                            num = ay * (ax * pix[8*k +: 8] + bx * left_cur[8*k +: 8])
                                + by * (ax * up[8*k +: 8] + bx * left_up[8*k +: 8]);
                            v = (2 * num + den) / (2 * den);
                            if (v > 255) v = 255;
                        end
                        o.val[k] = v;
                    end
                    expected_pixels.push_back(o);
                    n++;
                end
            end
            if (n > 0) expected_pixels[$].last = 1;
        end
        prev_line[col] = pix;
        left_up = up;
        left_cur = pix;
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) row = 0;
        end
    endfunction

    function void check_result(t_out_pixel got);
        t_out_pixel want;
        int unsigned e[7], a[7];
        string names[7];
        if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected output pixel x=%0d y=%0d", $time, got.px, got.py);
            errors++;
            return;
        end
        want = expected_pixels.pop_front();
        names = '{"out_x", "out_y", "value_a", "value_b", "value_c", "value_d", "run_end"};
        e = '{want.px, want.py, want.val[0], want.val[1], want.val[2], want.val[3], want.last};
        a = '{got.px, got.py, got.val[0], got.val[1], got.val[2], got.val[3], got.last};
        for (int i = 0; i < 7; i++) begin
            if (e[i] != a[i]) begin
                $display("%0t: %s expected %0d actual %0d", $time, names[i], e[i], a[i]);
                errors++;
            end
        end
    endfunction

    function int pending();
        return expected_pixels.size();
    endfunction
endclass

module testbench;
    import bis_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;

    bis_pix_if pix();
    bis_res_if res();
    bis_cfg_if cfg();

    bilinear_image_scaler u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix),
        .o_res  (res),
        .i_cfg  (cfg)
    );

    scaler_scoreboard sb = new();

    // When calm is set neither side idles; hold_output asks the receiver for one
    // long stall while the sender keeps offering pixels.
    bit calm = 0;
    bit hold_output = 0;
    int pixels_sent = 0;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    // Output side: check every transfer and choose ready for the next cycle.
    initial begin
        t_out_pixel got;
        res.ready <= 0;
        forever begin
            @(posedge i_clk);
            if (res.valid && res.ready) begin
                got.px = res.out_x;
                got.py = res.out_y;
                got.val = '{res.value_a, res.value_b, res.value_c, res.value_d};
                got.last = res.run_end;
                sb.check_result(got);
            end
            if (hold_output) begin
                // Long stall counted here, so the pipeline fills and the input stalls.
                hold_output = 0;
                res.ready <= 0;
                repeat (400) @(posedge i_clk);
                res.ready <= 1;
            end else begin
                res.ready <= calm || ($urandom_range(0, 99) >= 17);
            end
        end
    end

    // Offers one pixel and returns at the edge of its transfer. Valid stays high
    // unless a random gap follows, so back-to-back pixels need only one assignment.
    task automatic send_pixel(bit [31:0] p);
        pix.valid <= 1;
        {pix.sample_d, pix.sample_c, pix.sample_b, pix.sample_a} <= p;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        sb.note_pixel(p);
        pixels_sent++;
        if (!calm && $urandom_range(0, 99) < 17) begin
            pix.valid <= 0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // Random pixel, biased toward the lane extremes now and then.
    function automatic bit [31:0] rand_pixel();
        bit [31:0] p;
        p = $urandom;
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 9))
                0: p[8*k +: 8] = 8'h00;
                1: p[8*k +: 8] = 8'hFF;
                default: ;
            endcase
        end
        return p;
    endfunction

    // Lets the block drain: all results in, then enough cycles for a pixel whose
    // cell holds no output pixel and the line update to finish.
    task automatic drain();
        pix.valid <= 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, int data);
        cfg.valid <= 1;
        cfg.reg_index <= idx;
        cfg.wr_data <= 13'(data);
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        sb.write_reg(idx, 13'(data));
    endtask

    // Writes all five registers, then drops the write valid.
    task automatic set_sizes(int iw, int ih, int ow, int oh, int ch);
        write_reg(CFG_IN_WIDTH, iw);
        write_reg(CFG_IN_HEIGHT, ih);
        write_reg(CFG_OUT_WIDTH, ow);
        write_reg(CFG_OUT_HEIGHT, oh);
        write_reg(CFG_CHANNELS, ch);
        cfg.valid <= 0;
    endtask

    task automatic send_frame(int n);
        for (int i = 0; i < n; i++) send_pixel(rand_pixel());
    endtask

    initial begin
        int iw, ih, ow, oh, phase;
        pix.valid <= 0;
        pix.sample_a <= 0; pix.sample_b <= 0; pix.sample_c <= 0; pix.sample_d <= 0;
        cfg.valid <= 0;
        cfg.reg_index <= CFG_IN_WIDTH;
        cfg.wr_data <= 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Reset sizes: a 2x2 frame maps to itself, lanes at their extremes.
        send_pixel(32'h00000000);
        send_pixel(32'hFFFFFFFF);
        send_pixel(32'hFF00FF00);
        send_pixel(32'h00FF00FF);
        drain();

        // Fourfold upscale of a 3x3 frame with all four lanes.
        set_sizes(3, 3, 12, 12, 4);
        send_frame(9);
        drain();

        // Out-of-range values are clamped: 2x2 input, 4096x4096 output and four
        // lanes, so the only cell is cut at 64 results.
        set_sizes(1, 0, 13'h1FFF, 13'h1FFF, 7);
        send_frame(4);
        drain();

        // Downscale where some cells hold no output pixel; zero lanes means one.
        set_sizes(9, 3, 2, 2, 0);
        send_frame(27);
        drain();

        // Width shrunk mid-frame: the column counter wraps into the next row.
        set_sizes(4, 3, 7, 5, 2);
        send_frame(6);
        drain();
        write_reg(CFG_IN_WIDTH, 2);
        cfg.valid <= 0;
        send_frame(2);
        drain();

        // Widest input with a partial first row, then shrunk so the frame closes.
        set_sizes(2047, 2, 5, 3, 3);
        send_frame(5);
        drain();
        write_reg(CFG_IN_WIDTH, 2);
        cfg.valid <= 0;
        send_frame(2);
        drain();

        // Random whole frames of small sizes, some up to the fourfold limit.
        phase = 0;
        while (pixels_sent < 420) begin
            iw = $urandom_range(2, 8);
            ih = $urandom_range(2, 6);
            ow = $urandom_range(2, 4 * iw);
            oh = $urandom_range(2, 4 * ih);
            set_sizes(iw, ih, ow, oh, $urandom_range(1, 4));
            calm = (phase == 3 || phase == 4);
            if (phase == 1) hold_output = 1;
            for (int i = 0; i < iw * ih; i++) begin
                // Once, mid-frame, wait for every outstanding result before going on.
                if (phase == 2 && i == iw * ih / 2) begin
                    pix.valid <= 0;
                    while (sb.pending() != 0) @(posedge i_clk);
                    @(posedge i_clk);
                end
                send_pixel(rand_pixel());
            end
            drain();
            calm = 0;
            phase++;
        end

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("testbench failed");
        $finish;
    end
endmodule
`default_nettype wire
